FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: sv/mdm_pkg.sv
// Shared types and constants of the multiply/divide/modulo chain evaluator.
// No dependencies; imported by the controller, the datapath and the top level.
package mdm_pkg;

	localparam int DW    = 64;             // arithmetic width of the accumulator
	localparam int OUT_W = 64;             // width of the operand and result fields
	localparam int CW    = $clog2(DW);     // iteration counter width

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_MUL  = 2'd1;
	localparam logic [1:0] OP_DIV  = 2'd2;
	localparam logic [1:0] OP_MOD  = 2'd3;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [OUT_W-1:0] operand_value;
		logic                    last_operand;
	} in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] result_value;
		logic                    divide_by_zero;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_COMMIT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;   // take the request and set up the iteration registers
		logic mul_step;  // one shift-add step
		logic div_step;  // one restoring divide step
		logic commit;    // write the accumulator and the error flag
		logic emit;      // load the output register and clear the chain state
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_load;
		logic is_mul;
		logic div_zero;
		logic last;
		logic cnt_done;
	} stat_t;

endpackage

FILE: sv/mdm_datapath.sv
// Datapath: accumulator, error flag, shared shift-add / restoring-divide registers,
// sign fix-up and output register. Depends on mdm_pkg.
module mdm_datapath import mdm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  in_t   in_data,
	output stat_t stat,
	output out_t  out_data
);

	logic [1:0]    op_q;
	logic          last_q;
	logic [DW-1:0] b_q;
	logic [DW-1:0] acc_q;
	logic          err_q;
	logic [DW-1:0] work_a_q;   // multiplicand, or dividend shifting into quotient
	logic [DW-1:0] work_b_q;   // multiplier, or divisor magnitude
	logic [DW-1:0] work_r_q;   // product, or partial remainder
	logic          q_neg_q;
	logic          r_neg_q;
	logic [CW-1:0] cnt_q;
	out_t          out_q;

	logic [DW-1:0] b_in;
	logic          a_neg;
	logic          b_neg;
	logic [DW-1:0] a_mag;
	logic [DW-1:0] b_mag;
	logic [DW:0]   rem_sh;
	logic [DW:0]   diff;
	logic          is_divmod;
	logic [DW-1:0] acc_next;
	logic          err_next;

	assign b_in  = in_data.operand_value[DW-1:0];
	assign a_neg = acc_q[DW-1];
	assign b_neg = b_in[DW-1];
	assign a_mag = a_neg ? (~acc_q + 1'b1) : acc_q;
	assign b_mag = b_neg ? (~b_in + 1'b1) : b_in;

	assign rem_sh = {work_r_q, work_a_q[DW-1]};
	assign diff   = rem_sh - {1'b0, work_b_q};

	assign is_divmod = (op_q == OP_DIV) || (op_q == OP_MOD);

	always_comb begin
		acc_next = acc_q;
		err_next = err_q;
		case (op_q)
			OP_LOAD: acc_next = b_q;
			OP_MUL:  acc_next = work_r_q;
			OP_DIV: begin
				if (stat.div_zero) begin
					err_next = 1'b1;
				end else begin
					acc_next = q_neg_q ? (~work_a_q + 1'b1) : work_a_q;
				end
			end
			OP_MOD: begin
				if (stat.div_zero) begin
					err_next = 1'b1;
				end else begin
					acc_next = r_neg_q ? (~work_r_q + 1'b1) : work_r_q;
				end
			end
			default: acc_next = acc_q;
		endcase
	end

	assign stat.is_load  = (op_q == OP_LOAD);
	assign stat.is_mul   = (op_q == OP_MUL);
	assign stat.div_zero = is_divmod && (b_q == '0);
	assign stat.last     = last_q;
	assign stat.cnt_done = (cnt_q == CW'(DW - 1));

	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_LOAD;
			last_q <= 1'b0;
			acc_q  <= '0;
			err_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (cmd.capture) begin
				op_q   <= in_data.operation;
				last_q <= in_data.last_operand;
				cnt_q  <= '0;
			end else if (cmd.mul_step || cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				// chain ends: drop accumulator and error flag
				acc_q <= '0;
				err_q <= 1'b0;
			end else if (cmd.commit) begin
				acc_q <= acc_next;
				err_q <= err_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			b_q      <= b_in;
			q_neg_q  <= a_neg ^ b_neg;
			r_neg_q  <= a_neg;
			work_r_q <= '0;
			if (in_data.operation == OP_MUL) begin
				work_a_q <= acc_q;
				work_b_q <= b_in;
			end else begin
				work_a_q <= a_mag;
				work_b_q <= b_mag;
			end
		end else if (cmd.mul_step) begin
			if (work_b_q[0]) begin
				work_r_q <= work_r_q + work_a_q;
			end
			work_a_q <= {work_a_q[DW-2:0], 1'b0};
			work_b_q <= {1'b0, work_b_q[DW-1:1]};
		end else if (cmd.div_step) begin
			if (!diff[DW]) begin
				work_r_q <= diff[DW-1:0];
				work_a_q <= {work_a_q[DW-2:0], 1'b1};
			end else begin
				work_r_q <= rem_sh[DW-1:0];
				work_a_q <= {work_a_q[DW-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			out_q.divide_by_zero <= err_next;
			out_q.result_value   <= err_next ? '0 : OUT_W'(signed'(acc_next));
		end
	end

endmodule

FILE: sv/mdm_controller.sv
// Controller state machine: sequences capture, iteration, commit and result hand-off.
// Depends on mdm_pkg; drives the datapath through cmd_t and reads stat_t.
module mdm_controller import mdm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.is_load || stat.div_zero) begin
					state_d = ST_COMMIT;
				end else begin
					cmd.mul_step = stat.is_mul;
					cmd.div_step = !stat.is_mul;
					if (stat.cnt_done) begin
						state_d = ST_COMMIT;
					end
				end
			end
			ST_COMMIT: begin
				// hold a final request until the output register can take it
				if (!stat.last || out_free) begin
					cmd.commit = 1'b1;
					cmd.emit   = stat.last;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: sv/mul_div_mod_chain_evaluator_unit.sv
// Usage notes
// Evaluates a left-to-right chain of signed 64-bit operands joined by multiply,
// divide or modulo, keeping a running accumulator between requests.
// Input channel in_valid/in_ready/in_data: one request carries an operation
// (load, multiply, divide, modulo), an operand and a last-operand mark.
// Output channel out_valid/out_ready/out_data: one result per chain, sent for
// the request marked last; the chain state is then cleared.
// A multiply or a divide/modulo runs one bit per cycle through the shared
// shift-add / restoring-divide registers: a capture, one step per operand bit
// and a commit come before the next in_ready; a load or a zero divisor skips
// the steps. The result appears in out_data in the cycle after the commit.
// The output register decouples the two sides: new requests are taken while a
// result waits. Only a last request that finds the output register still full
// waits in its commit cycle until out_ready frees it.
// Reset (arst_n low) clears the accumulator, the error flag and all valid state.
// A zero divisor sets a sticky error; the chain's result is then 0 with
// divide_by_zero set.
// Depends on mdm_pkg, mdm_controller, mdm_datapath and assert_macros.svh.
`include "assert_macros.svh"

module mul_div_mod_chain_evaluator_unit import mdm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	cmd_t  cmd;
	stat_t stat;

	mdm_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mdm_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.stat     (stat),
		.out_data (out_data)
	);

	`ASSERT_NEVER(a_no_overwrite, cmd.emit && out_valid && !out_ready, "result overwritten")
	`ASSERT_CLK(a_emit_commits, cmd.emit |-> cmd.commit, "emit without commit")
	`ASSERT_CLK(a_no_early_result, (in_valid && in_ready) |=> !$rose(out_valid), "result too early")
	`ASSERT_CLK(a_zero_div_flag, (cmd.emit && stat.div_zero) |=> (out_data.divide_by_zero && out_data.result_value == '0), "zero divisor not flagged")

endmodule
